/* hdl/assert_macros.svh */
// Assertion helpers shared by the deframer modules.
// Each check is sampled on the rising clock and is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define CHK_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CHK_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

/* hdl/alpd_pkg.sv */
package alpd_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PREFIX_LEN  = 4;
    localparam int unsigned LEN_W       = 64;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd4194304;
    localparam logic [7:0]  MAX_LINE_RST    = 8'd64;
    localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;
    localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
    localparam logic [7:0]  DIGIT_NINE      = 8'h39;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_LINE_LONG = 3'd1,
        ERR_PREFIX    = 3'd2,
        ERR_LENGTH    = 3'd3,
        ERR_TOO_LARGE = 3'd4
    } t_err;

    typedef enum logic {
        CFG_MAX_PAYLOAD = 1'b0,
        CFG_MAX_LINE    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
        t_err       code;
    } t_result;

    // Expected header prefix "LEN ", one character per position.
    function automatic logic [7:0] hdr_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h4C;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h4E;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

/* hdl/ascii_length_prefix_deframer.sv */
// Channel   Direction  Handshake           Request payload
// input     in         i_valid / o_stall   i_rx_byte
// output    out        o_valid / i_stall   o_out_kind, o_out_byte, o_out_last, o_error_code
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One request is taken per cycle while o_stall is low; each result is written into the
// result queue at the edge that takes its request and is offered once it is at the queue's head.
// Reset (i_rst_n low, synchronous) empties the queue and restores both limits.
// o_stall rises only when the result queue holds P_QUEUE_DEPTH results.
// The parser keeps running while results wait, until that queue is full.
`include "assert_macros.svh"

module ascii_length_prefix_deframer #(
    parameter int unsigned P_QUEUE_DEPTH = alpd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [2:0]  o_error_code,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic              full;
    logic              push;
    alpd_pkg::t_result res;

    // Stall the input side only while the queue cannot take another result.
    assign o_stall = full;

    // Front: parse header lines, count payload bytes, classify every request.
    alpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_rx_byte  (i_rx_byte),
        .i_full     (full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_res      (res)
    );

    // Back: hold results and hand them out at the downstream's pace.
    alpd_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_res        (res),
        .i_stall      (i_stall),
        .o_full       (full),
        .o_valid      (o_valid),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_error_code (o_error_code)
    );

endmodule

/* hdl/alpd_front.sv */
`include "assert_macros.svh"

module alpd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_rx_byte,
    input  logic                   i_full,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [31:0]            i_cfg_data,
    output logic                   o_push,
    output alpd_pkg::t_result      o_res
);

    logic        r_in_payload, n_in_payload;
    logic [7:0]  r_line, n_line;
    logic        r_prefix_ok, n_prefix_ok;
    logic        r_digits, n_digits;
    logic        r_nondigit, n_nondigit;
    logic [alpd_pkg::LEN_W-1:0] r_len, n_len;
    logic        r_ovf, n_ovf;
    logic [31:0] r_left, n_left;
    logic [31:0] r_max_payload;
    logic [7:0]  r_max_line;

    logic                         acc;
    logic [alpd_pkg::LEN_W+3:0]   len_x10;
    logic [8:0]                   line_inc;
    logic                         too_large;

    assign acc      = i_valid && !i_full;
    assign line_inc = {1'b0, r_line} + 9'd1;
    // value * 10 + digit, four guard bits catch a 64-bit overflow
    assign len_x10  = ({4'd0, r_len} << 3) + ({4'd0, r_len} << 1)
                    + (alpd_pkg::LEN_W+4)'(i_rx_byte - alpd_pkg::DIGIT_ZERO);
    assign too_large = (|r_len[alpd_pkg::LEN_W-1:32]) || (r_len[31:0] > r_max_payload);

    always_comb begin
        n_in_payload = r_in_payload;
        n_line       = r_line;
        n_prefix_ok  = r_prefix_ok;
        n_digits     = r_digits;
        n_nondigit   = r_nondigit;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_left       = r_left;
        o_push       = 1'b0;
        o_res.kind   = alpd_pkg::KIND_ERROR;
        o_res.data   = 8'd0;
        o_res.last   = 1'b0;
        o_res.code   = alpd_pkg::ERR_NONE;
        if (acc) begin
            if (r_in_payload) begin
                n_left     = r_left - 32'd1;
                o_push     = 1'b1;
                o_res.kind = alpd_pkg::KIND_PAYLOAD;
                o_res.data = i_rx_byte;
                o_res.last = (r_left == 32'd1);
                if (r_left == 32'd1) begin
                    n_in_payload = 1'b0;
                end
            end else if (i_rx_byte != alpd_pkg::NEWLINE_BYTE) begin
                if (line_inc > {1'b0, r_max_line}) begin
                    o_push     = 1'b1;
                    o_res.code = alpd_pkg::ERR_LINE_LONG;
                end else begin
                    n_line = line_inc[7:0];
                    if (r_line < 8'(alpd_pkg::PREFIX_LEN)) begin
                        if (i_rx_byte != alpd_pkg::hdr_char(r_line[1:0])) begin
                            n_prefix_ok = 1'b0;
                        end
                    end else if (i_rx_byte inside {[alpd_pkg::DIGIT_ZERO:
                                                    alpd_pkg::DIGIT_NINE]}) begin
                        n_digits = 1'b1;
                        n_len    = len_x10[alpd_pkg::LEN_W-1:0];
                        if (|len_x10[alpd_pkg::LEN_W+3:alpd_pkg::LEN_W]) begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_nondigit = 1'b1;
                    end
                end
            end else begin
                if (!r_prefix_ok || r_line < 8'(alpd_pkg::PREFIX_LEN)) begin
                    o_push     = 1'b1;
                    o_res.code = alpd_pkg::ERR_PREFIX;
                end else if (!r_digits || r_nondigit || r_ovf) begin
                    o_push     = 1'b1;
                    o_res.code = alpd_pkg::ERR_LENGTH;
                end else if (too_large) begin
                    o_push     = 1'b1;
                    o_res.code = alpd_pkg::ERR_TOO_LARGE;
                end else if (r_len[31:0] == 32'd0) begin
                    o_push     = 1'b1;
                    o_res.kind = alpd_pkg::KIND_EMPTY;
                    o_res.last = 1'b1;
                end else begin
                    n_left       = r_len[31:0];
                    n_in_payload = 1'b1;
                end
            end
            // every result and every newline ends the header line
            if (o_push || i_rx_byte == alpd_pkg::NEWLINE_BYTE || r_in_payload) begin
                if (o_push || !r_in_payload) begin
                    n_line      = 8'd0;
                    n_prefix_ok = 1'b1;
                    n_digits    = 1'b0;
                    n_nondigit  = 1'b0;
                    n_len       = '0;
                    n_ovf       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload  <= 1'b0;
            r_line        <= 8'd0;
            r_prefix_ok   <= 1'b1;
            r_digits      <= 1'b0;
            r_nondigit    <= 1'b0;
            r_len         <= '0;
            r_ovf         <= 1'b0;
            r_left        <= 32'd0;
            r_max_payload <= alpd_pkg::MAX_PAYLOAD_RST;
            r_max_line    <= alpd_pkg::MAX_LINE_RST;
        end else begin
            r_in_payload <= n_in_payload;
            r_line       <= n_line;
            r_prefix_ok  <= n_prefix_ok;
            r_digits     <= n_digits;
            r_nondigit   <= n_nondigit;
            r_len        <= n_len;
            r_ovf        <= n_ovf;
            r_left       <= n_left;
            if (i_cfg_we) begin
                case (alpd_pkg::t_cfg_idx'(i_cfg_idx))
                    alpd_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                    alpd_pkg::CFG_MAX_LINE:    r_max_line    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    `CHK_ALWAYS(a_payload_count, !r_in_payload || r_left != 32'd0,
        "payload mode with no bytes left")
    `CHK_SAME(a_payload_push, acc && r_in_payload,
        o_push && o_res.kind == alpd_pkg::KIND_PAYLOAD,
        "payload byte accepted without a payload result")
    `CHK_NEXT(a_result_clears, o_push && o_res.kind != alpd_pkg::KIND_PAYLOAD,
        !r_in_payload && r_line == 8'd0,
        "header state not cleared after a header result")

endmodule

/* hdl/alpd_queue.sv */
`include "assert_macros.svh"

module alpd_queue #(
    parameter int unsigned P_DEPTH = alpd_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  alpd_pkg::t_result      i_res,
    input  logic                   i_stall,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [1:0]             o_out_kind,
    output logic [7:0]             o_out_byte,
    output logic                   o_out_last,
    output logic [2:0]             o_error_code
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);

    alpd_pkg::t_result r_mem [P_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              pop;
    alpd_pkg::t_result head;

    assign o_full  = (r_cnt == CNT_W'(P_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign head    = r_mem[r_rd];

    assign o_out_kind   = head.kind;
    assign o_out_byte   = head.data;
    assign o_out_last   = head.last;
    assign o_error_code = head.code;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    `CHK_SAME(a_no_overrun, o_full, !i_push, "push into a full queue")
    `CHK_ALWAYS(a_count_range, r_cnt <= CNT_W'(P_DEPTH), "queue count out of range")

endmodule
